>>> rtl/core/ipsc_pkg.sv
// ----------------------------------------------------------------------------
// ipsc_pkg
// Shared types and constants of the incremental PI servo controller.
// ----------------------------------------------------------------------------
package ipsc_pkg;

    // Defaults of the top-level parameters.
    localparam int FRAC_BITS_DEF  = 8;
    localparam int PULSE_BITS_DEF = 12;

    // Field and datapath widths.
    localparam int IN_W        = 24;
    localparam int ERR_W       = 25;
    localparam int DIFF_W      = 26;
    localparam int GAIN_W      = 16;
    localparam int MUL_B_W     = 17;
    localparam int PROD_W      = 43;
    localparam int ACC_W       = 44;
    localparam int STEP_W      = 11;
    localparam int LIMIT_W     = 10;
    localparam int CFG_PULSE_W = 12;
    localparam int OUT_PULSE_W = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;
    localparam int STEP_CNT_W  = 4;

    // Speed-mode scaling: about 0.02 as 5243 / 2^18.
    localparam logic signed [MUL_B_W-1:0] SPEED_MUL   = 17'sd5243;
    localparam int                        SPEED_SHIFT = 18;

    // Register reset values.
    localparam logic [GAIN_W-1:0]      GAIN_PROP_RST     = 16'd256;
    localparam logic [GAIN_W-1:0]      GAIN_INTEGRAL_RST = 16'd256;
    localparam logic [GAIN_W-1:0]      DEADBAND_RST      = 16'd256;
    localparam logic [LIMIT_W-1:0]     STEP_LIMIT_RST    = 10'd50;
    localparam logic [CFG_PULSE_W-1:0] PULSE_HOME_RST    = 12'd1500;
    localparam logic [CFG_PULSE_W-1:0] PULSE_FLOOR_RST   = 12'd1000;
    localparam logic [CFG_PULSE_W-1:0] PULSE_CEILING_RST = 12'd2000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_MODE    = 3'd0,
        CFG_GAIN_PROP     = 3'd1,
        CFG_GAIN_INTEGRAL = 3'd2,
        CFG_DEADBAND      = 3'd3,
        CFG_STEP_LIMIT    = 3'd4,
        CFG_PULSE_HOME    = 3'd5,
        CFG_PULSE_FLOOR   = 3'd6,
        CFG_PULSE_CEILING = 3'd7
    } ipsc_cfg_idx_t;

    // Datapath operations, one per microcode word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SCALE,
        OP_DEAD,
        OP_MULP,
        OP_MULI,
        OP_ADD,
        OP_TRUNC,
        OP_CLAMP,
        OP_CEIL,
        OP_FLOOR,
        OP_HOME,
        OP_HOLD,
        OP_OUT
    } ipsc_op_t;

    // Jump conditions of the sequencer.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DISABLED,
        COND_IN_DEADBAND,
        COND_OUT_BUSY
    } ipsc_cond_t;

    // One control word of the program.
    typedef struct packed {
        ipsc_op_t               op;
        ipsc_cond_t             cond;
        logic                   hold;
        logic [STEP_CNT_W-1:0]  target;
    } ipsc_uword_t;

    // Datapath flags that the sequencer branches on.
    typedef struct packed {
        logic disabled;
        logic in_deadband;
        logic out_busy;
    } ipsc_status_t;

endpackage

>>> rtl/core/ipsc_seq.sv
// ----------------------------------------------------------------------------
// ipsc_seq
// Microcode sequencer: step counter, program table and conditional jumps.
// ----------------------------------------------------------------------------
module ipsc_seq
    import ipsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  ipsc_status_t status,
    output ipsc_op_t     op,
    output logic         in_ready
);

    // Program addresses.
    localparam logic [STEP_CNT_W-1:0] ST_WAIT   = 4'd0;
    localparam logic [STEP_CNT_W-1:0] ST_SCALE  = 4'd1;
    localparam logic [STEP_CNT_W-1:0] ST_DEAD   = 4'd2;
    localparam logic [STEP_CNT_W-1:0] ST_MULP   = 4'd3;
    localparam logic [STEP_CNT_W-1:0] ST_MULI   = 4'd4;
    localparam logic [STEP_CNT_W-1:0] ST_ADD    = 4'd5;
    localparam logic [STEP_CNT_W-1:0] ST_TRUNC  = 4'd6;
    localparam logic [STEP_CNT_W-1:0] ST_CLAMP  = 4'd7;
    localparam logic [STEP_CNT_W-1:0] ST_CEIL   = 4'd8;
    localparam logic [STEP_CNT_W-1:0] ST_FLOOR  = 4'd9;
    localparam logic [STEP_CNT_W-1:0] ST_HOME   = 4'd10;
    localparam logic [STEP_CNT_W-1:0] ST_HOLD   = 4'd11;
    localparam logic [STEP_CNT_W-1:0] ST_FINISH = 4'd15;

    // The program. A word with hold set suppresses its operation while its
    // condition is true; FINISH is the last address so falling through
    // wraps back to WAIT.
    function automatic ipsc_uword_t ucode(input logic [STEP_CNT_W-1:0] addr);
        ipsc_uword_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, hold: 1'b0, target: ST_WAIT};
        unique case (addr)
            ST_WAIT:   w = '{op: OP_LOAD,  cond: COND_NO_INPUT,    hold: 1'b1,
                             target: ST_WAIT};
            ST_SCALE:  w = '{op: OP_SCALE, cond: COND_DISABLED,    hold: 1'b0,
                             target: ST_HOME};
            ST_DEAD:   w = '{op: OP_DEAD,  cond: COND_IN_DEADBAND, hold: 1'b0,
                             target: ST_HOLD};
            ST_MULP:   w = '{op: OP_MULP,  cond: COND_NEVER,  hold: 1'b0, target: ST_WAIT};
            ST_MULI:   w = '{op: OP_MULI,  cond: COND_NEVER,  hold: 1'b0, target: ST_WAIT};
            ST_ADD:    w = '{op: OP_ADD,   cond: COND_NEVER,  hold: 1'b0, target: ST_WAIT};
            ST_TRUNC:  w = '{op: OP_TRUNC, cond: COND_NEVER,  hold: 1'b0, target: ST_WAIT};
            ST_CLAMP:  w = '{op: OP_CLAMP, cond: COND_NEVER,  hold: 1'b0, target: ST_WAIT};
            ST_CEIL:   w = '{op: OP_CEIL,  cond: COND_NEVER,  hold: 1'b0, target: ST_WAIT};
            ST_FLOOR:  w = '{op: OP_FLOOR, cond: COND_ALWAYS, hold: 1'b0, target: ST_FINISH};
            ST_HOME:   w = '{op: OP_HOME,  cond: COND_ALWAYS, hold: 1'b0, target: ST_FINISH};
            ST_HOLD:   w = '{op: OP_HOLD,  cond: COND_ALWAYS, hold: 1'b0, target: ST_FINISH};
            ST_FINISH: w = '{op: OP_OUT,   cond: COND_OUT_BUSY,    hold: 1'b1,
                             target: ST_FINISH};
            default:   w = '{op: OP_NOP,   cond: COND_ALWAYS, hold: 1'b0, target: ST_WAIT};
        endcase
        return w;
    endfunction

    logic [STEP_CNT_W-1:0] step_reg;
    logic [STEP_CNT_W-1:0] step_next;
    ipsc_uword_t           uword;
    logic                  cond_true;

    // Condition select.
    always_comb
    begin
        uword = ucode(step_reg);
        unique case (uword.cond)
            COND_NEVER:       cond_true = 1'b0;
            COND_ALWAYS:      cond_true = 1'b1;
            COND_NO_INPUT:    cond_true = !in_valid;
            COND_DISABLED:    cond_true = status.disabled;
            COND_IN_DEADBAND: cond_true = status.in_deadband;
            COND_OUT_BUSY:    cond_true = status.out_busy;
            default:          cond_true = 1'b0;
        endcase
    end

    // Next address and issued operation.
    always_comb
    begin
        step_next = cond_true ? uword.target : STEP_CNT_W'(step_reg + 1'b1);
        op        = (uword.hold && cond_true) ? OP_NOP : uword.op;
        in_ready  = (step_reg == ST_WAIT);
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // An accepted transfer always starts the program at the scaling step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> step_reg == ST_SCALE)
        else $error("accepted transfer did not start the program");

    // A result held back by the output side keeps the sequencer in FINISH.
    a_finish_stall: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ST_FINISH && status.out_busy |=> step_reg == ST_FINISH)
        else $error("sequencer left FINISH while the output was busy");

endmodule

>>> rtl/core/ipsc_dp.sv
// ----------------------------------------------------------------------------
// ipsc_dp
// Datapath: configuration registers, shared multiplier, error and pulse state,
// and the output register.
// ----------------------------------------------------------------------------
module ipsc_dp
    import ipsc_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int PULSE_BITS = PULSE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  ipsc_op_t               op,
    output ipsc_status_t           status,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int TRUNC_SHIFT = 2 * FRAC_BITS;
    localparam int PSUM_W      = ((PULSE_BITS > STEP_W) ? PULSE_BITS : STEP_W) + 2;
    localparam logic [ACC_W-1:0] TRUNC_BIAS = (ACC_W'(1) << TRUNC_SHIFT) - ACC_W'(1);

    // Configuration registers.
    logic                  speed_mode_reg;
    logic [GAIN_W-1:0]     gain_prop_reg;
    logic [GAIN_W-1:0]     gain_integral_reg;
    logic [GAIN_W-1:0]     deadband_reg;
    logic [LIMIT_W-1:0]    step_limit_reg;
    logic [PULSE_BITS-1:0] pulse_home_reg;
    logic [PULSE_BITS-1:0] pulse_floor_reg;
    logic [PULSE_BITS-1:0] pulse_ceiling_reg;

    // Controller state.
    logic signed [ERR_W-1:0] prev_err_reg;
    logic [PULSE_BITS-1:0]   pulse_reg;
    logic                    m_tvalid_reg;

    // Working registers.
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic signed [PSUM_W-1:0] psum_reg;
    logic                     en_reg;
    logic                     written_reg;

    // Output register.
    logic [OUT_PULSE_W-1:0] out_pulse_reg;
    logic                   out_written_reg;
    logic [STEP_W-1:0]      out_step_reg;

    // Combinational terms.
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ERR_W-1:0]   in_err;
    logic [ERR_W-1:0]          err_mag;
    logic signed [ACC_W-1:0]   acc_biased;
    logic signed [ACC_W-1:0]   acc_trunc;
    logic signed [ACC_W-1:0]   lim_pos;
    logic signed [ACC_W-1:0]   lim_neg;
    logic signed [STEP_W-1:0]  step_clamped;
    logic signed [PSUM_W-1:0]  pulse_ext;
    logic signed [PSUM_W-1:0]  step_ext;
    logic signed [PSUM_W-1:0]  ceil_ext;
    logic signed [PSUM_W-1:0]  floor_ext;
    logic signed [PSUM_W-1:0]  psum;
    logic signed [PSUM_W-1:0]  psum_ceiled;
    logic signed [PSUM_W-1:0]  psum_floored;
    logic                      out_load;

    // Raw error from the incoming transfer.
    assign in_err = $signed({1'b0, in_data[IN_W-1:0]}) - $signed({1'b0, in_data[2*IN_W-1:IN_W]});

    // Shared multiplier and its operand selection.
    always_comb
    begin
        mul_a = (op == OP_MULP) ? diff_reg : {err_reg[ERR_W-1], err_reg};
        unique case (op)
            OP_MULP: mul_b = $signed({1'b0, gain_prop_reg});
            OP_MULI: mul_b = $signed({1'b0, gain_integral_reg});
            default: mul_b = SPEED_MUL;
        endcase
        mul_p = mul_a * mul_b;
    end

    // Deadband test on the magnitude of the error.
    assign err_mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);

    // Division by 2^(2*FRAC_BITS), truncating toward zero.
    assign acc_biased = acc_reg + (acc_reg[ACC_W-1] ? $signed(TRUNC_BIAS) : $signed(ACC_W'(0)));
    assign acc_trunc  = acc_biased >>> TRUNC_SHIFT;

    // Step clamp to the symmetric limit.
    always_comb
    begin
        lim_pos = $signed({{(ACC_W-LIMIT_W){1'b0}}, step_limit_reg});
        lim_neg = -lim_pos;
        priority if (acc_reg > lim_pos)
            step_clamped = lim_pos[STEP_W-1:0];
        else if (acc_reg < lim_neg)
            step_clamped = lim_neg[STEP_W-1:0];
        else
            step_clamped = acc_reg[STEP_W-1:0];
    end

    // Pulse update: ceiling first, then floor, so the floor wins.
    always_comb
    begin
        pulse_ext = $signed({{(PSUM_W-PULSE_BITS){1'b0}}, pulse_reg});
        step_ext  = {{(PSUM_W-STEP_W){step_reg[STEP_W-1]}}, step_reg};
        ceil_ext  = $signed({{(PSUM_W-PULSE_BITS){1'b0}}, pulse_ceiling_reg});
        floor_ext = $signed({{(PSUM_W-PULSE_BITS){1'b0}}, pulse_floor_reg});
        psum      = pulse_ext + step_ext;
        psum_ceiled  = (psum > ceil_ext) ? ceil_ext : psum;
        psum_floored = (psum_reg < floor_ext) ? floor_ext : psum_reg;
    end

    // The output register takes a result when it is empty or being emptied.
    assign out_load = (op == OP_OUT) && (!m_tvalid_reg || m_axis_tready);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_mode_reg    <= 1'b0;
            gain_prop_reg     <= GAIN_PROP_RST;
            gain_integral_reg <= GAIN_INTEGRAL_RST;
            deadband_reg      <= DEADBAND_RST;
            step_limit_reg    <= STEP_LIMIT_RST;
            pulse_home_reg    <= PULSE_BITS'(PULSE_HOME_RST);
            pulse_floor_reg   <= PULSE_BITS'(PULSE_FLOOR_RST);
            pulse_ceiling_reg <= PULSE_BITS'(PULSE_CEILING_RST);
        end
        else if (cfg_we)
        begin
            unique case (ipsc_cfg_idx_t'(cfg_index))
                CFG_SPEED_MODE:    speed_mode_reg    <= cfg_wdata[0];
                CFG_GAIN_PROP:     gain_prop_reg     <= cfg_wdata;
                CFG_GAIN_INTEGRAL: gain_integral_reg <= cfg_wdata;
                CFG_DEADBAND:      deadband_reg      <= cfg_wdata;
                CFG_STEP_LIMIT:    step_limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                CFG_PULSE_HOME:    pulse_home_reg    <= PULSE_BITS'(cfg_wdata[CFG_PULSE_W-1:0]);
                CFG_PULSE_FLOOR:   pulse_floor_reg   <= PULSE_BITS'(cfg_wdata[CFG_PULSE_W-1:0]);
                CFG_PULSE_CEILING: pulse_ceiling_reg <= PULSE_BITS'(cfg_wdata[CFG_PULSE_W-1:0]);
                default:           speed_mode_reg    <= speed_mode_reg;
            endcase
        end
    end

    // Controller state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            pulse_reg    <= PULSE_BITS'(PULSE_HOME_RST);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_DEAD)
                prev_err_reg <= err_reg;
            else if (op == OP_HOME)
                prev_err_reg <= '0;

            if (op == OP_FLOOR)
                pulse_reg <= psum_floored[PULSE_BITS-1:0];
            else if (op == OP_HOME)
                pulse_reg <= pulse_home_reg;

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Working registers, one operation per cycle.
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                err_reg <= in_err;
                en_reg  <= in_data[2*IN_W] & in_data[2*IN_W+1];
            end
            OP_SCALE:
            begin
                if (speed_mode_reg)
                    err_reg <= mul_p[SPEED_SHIFT +: ERR_W];
            end
            OP_DEAD:  diff_reg <= DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);
            OP_MULP:  acc_reg  <= {mul_p[PROD_W-1], mul_p};
            OP_MULI:  prod_reg <= mul_p;
            OP_ADD:   acc_reg  <= acc_reg + {prod_reg[PROD_W-1], prod_reg};
            OP_TRUNC: acc_reg  <= acc_trunc;
            OP_CLAMP: step_reg <= step_clamped;
            OP_CEIL:  psum_reg <= psum_ceiled;
            OP_FLOOR: written_reg <= 1'b1;
            OP_HOME:
            begin
                step_reg    <= '0;
                written_reg <= 1'b1;
            end
            OP_HOLD:
            begin
                step_reg    <= '0;
                written_reg <= 1'b0;
            end
            default:  en_reg <= en_reg;
        endcase

        if (out_load)
        begin
            out_pulse_reg   <= OUT_PULSE_W'(pulse_reg);
            out_written_reg <= written_reg;
            out_step_reg    <= step_reg;
        end
    end

    // Status to the sequencer and output ports.
    assign status.disabled    = !en_reg;
    assign status.in_deadband = !(err_mag > ERR_W'(deadband_reg));
    assign status.out_busy    = m_tvalid_reg && !m_axis_tready;

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {out_step_reg, out_written_reg, out_pulse_reg};

    // A finished result shows up as a valid transfer in the next cycle.
    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid_reg)
        else $error("result was not presented after loading");

    // A tick that left the pulse alone reports no step.
    a_no_write_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !out_written_reg |-> out_step_reg == '0)
        else $error("nonzero step on a tick without a pulse write");

    // The reported step never exceeds the configured limit.
    a_step_limited: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> ($signed(out_step_reg) <= $signed({1'b0, step_limit_reg}))
                      && ($signed(out_step_reg) >= -$signed({1'b0, step_limit_reg})))
        else $error("step outside the configured limit");

endmodule

>>> rtl/core/incremental_pi_servo_controller.sv
// ----------------------------------------------------------------------------
// incremental_pi_servo_controller
// Velocity-form PI servo controller with deadband, one result per tick.
// ----------------------------------------------------------------------------
// Each input transfer is one control tick and yields exactly one output
// transfer. A tick that runs the full control law steps through load, speed
// scaling, deadband test, proportional and integral products, add, truncate,
// step clamp, ceiling and floor before it is loaded into the output register;
// a tick inside the deadband goes from the deadband test to hold, a disabled
// tick from scaling to home. The microcode program runs one datapath operation
// per cycle, except while it waits for input or for the output register,
// through a single shared multiplier (speed scaling, proportional and integral
// products each use it in turn). A new tick is accepted once the previous
// result sits in the output register, even if it has not yet been taken; while
// the output register still holds an untaken result, the program waits before
// loading the next one. Configuration registers are written through cfg_we,
// cfg_index and cfg_wdata and must only change while no tick is in flight.
module incremental_pi_servo_controller
    import ipsc_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int PULSE_BITS = PULSE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Tick input: target_value[23:0], measured_value[47:24],
    // engine_running[48], central_enable[49], zero fill [55:50].
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result: servo_pulse[11:0], pulse_written[12], step_applied[23:13].
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    ipsc_op_t     op;
    ipsc_status_t status;

    // Program sequencer.
    ipsc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .op       (op),
        .in_ready (s_axis_tready)
    );

    // Arithmetic datapath and output register.
    ipsc_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .PULSE_BITS (PULSE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_data       (s_axis_tdata),
        .op            (op),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
